[sv/mean_and_deviation_from_moments_top_assert.svh]
// Assertion macros shared by the statistics pipeline.
`ifndef MEAN_AND_DEVIATION_FROM_MOMENTS_TOP_ASSERT_SVH
`define MEAN_AND_DEVIATION_FROM_MOMENTS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define MDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define MDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mdm_pkg.sv]
// Types, constants and step functions of the statistics pipeline.
`timescale 1ns / 1ps
package mdm_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned WideW       = 96;
  localparam int unsigned RootW       = 48;
  localparam int unsigned SqRemW      = RootW + 3;
  localparam logic [RootW-1:0] RootMax = '1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_COUNT_ZERO = 2'd1,
    ST_COUNT_ONE  = 2'd2,
    ST_NEG_DIFF   = 2'd3
  } status_e;

  typedef struct packed {
    logic    vld;
    status_e status;
  } side_t;

  typedef struct packed {
    logic [WideW-1:0] rem;
    logic [WideW-1:0] quo;
    logic             ovf;
    logic [WideW-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    logic [WideW-1:0]  rad;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
    logic              sat;
  } sq_lane_t;

  // One restoring division step: bring in one dividend bit, make one quotient bit.
  function automatic div_lane_t div_step(div_lane_t l, logic b);
    logic [WideW:0] trial;
    div_lane_t      r;
    trial = {l.rem, b};
    r     = l;
    r.ovf = l.ovf | l.quo[WideW-1];
    if (trial >= {1'b0, l.dvs}) begin
      trial = trial - {1'b0, l.dvs};
      r.quo = {l.quo[WideW-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[WideW-2:0], 1'b0};
    end
    r.rem = trial[WideW-1:0];
    return r;
  endfunction

  // One digit-by-digit square root step: two radicand bits in, one root bit out.
  function automatic sq_lane_t sq_step(sq_lane_t l);
    logic [SqRemW-1:0] acc;
    logic [SqRemW-1:0] trial;
    sq_lane_t          r;
    acc   = {l.rem[SqRemW-3:0], l.rad[WideW-1 -: 2]};
    trial = {1'b0, l.root, 2'b01};
    r     = l;
    r.rad = {l.rad[WideW-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {l.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {l.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[sv/mdm_prep.sv]
// Front end: products, exact difference and divisors ahead of the divider chain.
`timescale 1ns / 1ps
module mdm_prep #(
  parameter int unsigned FRAC_BITS = mdm_pkg::FracBitsDef,
  parameter int unsigned DvdW      = mdm_pkg::WideW + 2 * FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 in_valid_i,
  input  logic [31:0]                          sample_sum_i,
  input  logic [63:0]                          square_sum_i,
  input  logic [31:0]                          sample_count_i,
  output mdm_pkg::side_t                       side_o,
  output logic [2:0][DvdW-1:0]                 dvd_o,
  output mdm_pkg::div_lane_t [2:0]             lane_o
);

  localparam int unsigned WW = mdm_pkg::WideW;

  mdm_pkg::side_t side0_q, side1_q, side2_q, side3_q, side0_d, side3_d;
  logic [31:0]    s0_q, s1_q, s2_q, s3_q;
  logic [31:0]    n0_q, n1_q, n2_q, n3_q;
  logic [63:0]    q0_q;
  logic [63:0]    plo_q, phi_q, ss1_q, ss2_q, nn1_q, nn1b_q, nn1c_q;
  logic [63:0]    nn2lo_q, nn2hi_q;
  logic [WW-1:0]  nq_q, d3_q, nn2_q;
  logic [WW:0]    diff_d;

  always_comb begin
    side0_d.vld = in_valid_i;
    if (sample_count_i == 32'd0) begin
      side0_d.status = mdm_pkg::ST_COUNT_ZERO;
    end else if (sample_count_i == 32'd1) begin
      side0_d.status = mdm_pkg::ST_COUNT_ONE;
    end else begin
      side0_d.status = mdm_pkg::ST_OK;
    end
  end

  always_comb begin
    diff_d  = {1'b0, nq_q} - {{(WW - 63){1'b0}}, ss2_q};
    side3_d = side2_q;
    if (side2_q.status == mdm_pkg::ST_OK && diff_d[WW]) begin
      side3_d.status = mdm_pkg::ST_NEG_DIFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
    end else if (en_i) begin
      side0_q <= side0_d;
      side1_q <= side0_q;
      side2_q <= side1_q;
      side3_q <= side3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q    <= sample_sum_i;
      q0_q    <= square_sum_i;
      n0_q    <= sample_count_i;
      plo_q   <= n0_q * q0_q[31:0];
      phi_q   <= n0_q * q0_q[63:32];
      ss1_q   <= s0_q * s0_q;
      nn1_q   <= n0_q * (n0_q - 32'd1);
      s1_q    <= s0_q;
      n1_q    <= n0_q;
      nq_q    <= {32'd0, plo_q} + {phi_q, 32'd0};
      nn2lo_q <= n1_q * nn1_q[31:0];
      nn2hi_q <= n1_q * nn1_q[63:32];
      ss2_q   <= ss1_q;
      nn1b_q  <= nn1_q;
      s2_q    <= s1_q;
      n2_q    <= n1_q;
      d3_q    <= diff_d[WW-1:0];
      nn2_q   <= {32'd0, nn2lo_q} + {nn2hi_q, 32'd0};
      nn1c_q  <= nn1b_q;
      s3_q    <= s2_q;
      n3_q    <= n2_q;
    end
  end

  assign side_o   = side3_q;
  assign dvd_o[0] = DvdW'(s3_q) << FRAC_BITS;
  assign dvd_o[1] = DvdW'(d3_q) << (2 * FRAC_BITS);
  assign dvd_o[2] = DvdW'(d3_q) << (2 * FRAC_BITS);

  always_comb begin
    lane_o        = '0;
    lane_o[0].dvs = WW'(n3_q);
    lane_o[1].dvs = WW'(nn1c_q);
    lane_o[2].dvs = nn2_q;
  end

endmodule

[sv/mdm_div_cell.sv]
// One divider cell: a quotient bit for each of the three division lanes.
`timescale 1ns / 1ps
module mdm_div_cell #(
  parameter int unsigned DvdW = mdm_pkg::WideW + 2 * mdm_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  mdm_pkg::side_t           side_i,
  output mdm_pkg::side_t           side_o,
  input  logic [2:0][DvdW-1:0]     dvd_i,
  output logic [2:0][DvdW-1:0]     dvd_o,
  input  mdm_pkg::div_lane_t [2:0] lane_i,
  output mdm_pkg::div_lane_t [2:0] lane_o
);

  mdm_pkg::side_t           side_q;
  logic [2:0][DvdW-1:0]     dvd_q, dvd_d;
  mdm_pkg::div_lane_t [2:0] lane_q, lane_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_d[k] = mdm_pkg::div_step(lane_i[k], dvd_i[k][DvdW-1]);
      dvd_d[k]  = dvd_i[k] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q  <= dvd_d;
      lane_q <= lane_d;
    end
  end

  assign side_o = side_q;
  assign dvd_o  = dvd_q;
  assign lane_o = lane_q;

endmodule

[sv/mdm_sq_cell.sv]
// One square root cell: a root bit for each of the two deviation lanes.
`timescale 1ns / 1ps
module mdm_sq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  mdm_pkg::side_t                side_i,
  output mdm_pkg::side_t                side_o,
  input  logic [mdm_pkg::RootW-1:0]     mean_i,
  output logic [mdm_pkg::RootW-1:0]     mean_o,
  input  mdm_pkg::sq_lane_t [1:0]       lane_i,
  output mdm_pkg::sq_lane_t [1:0]       lane_o
);

  mdm_pkg::side_t               side_q;
  logic [mdm_pkg::RootW-1:0]    mean_q;
  mdm_pkg::sq_lane_t [1:0]      lane_q, lane_d;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lane_d[k] = mdm_pkg::sq_step(lane_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mean_q <= mean_i;
      lane_q <= lane_d;
    end
  end

  assign side_o = side_q;
  assign mean_o = mean_q;
  assign lane_o = lane_q;

endmodule

[sv/mean_and_deviation_from_moments_top.sv]
// Top level: mean and sample standard deviation from running sums, one beat per cycle
// while no finished result is stalled.
//   channel | direction | handshake                | payload
//   in      | to block  | in_valid_i / in_stall_o  | sample_sum, square_sum, sample_count
//   out     | from block| out_valid_o / out_stall_i| mean_value, deviation,
//           |           |                          | deviation_of_mean, status
//
// The block takes one beat per cycle while the output is not stalled; a beat passes the
// prep stages, the bit-per-cell divider chain, the root chain and an output register.
// Reset clears all valid flags; there is no clearing pass.
// When a finished result is stalled, the whole chain holds and in_stall_o rises.
`timescale 1ns / 1ps
module mean_and_deviation_from_moments_top #(
  parameter int unsigned FRAC_BITS = mdm_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_sum_i,
  input  logic [63:0] square_sum_i,
  input  logic [31:0] sample_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] mean_value_o,
  output logic [47:0] deviation_o,
  output logic [47:0] deviation_of_mean_o,
  output logic [1:0]  status_o
);

  localparam int unsigned WW   = mdm_pkg::WideW;
  localparam int unsigned RW   = mdm_pkg::RootW;
  localparam int unsigned DvdW = WW + 2 * FRAC_BITS;

  logic en;

  mdm_pkg::side_t           dside [DvdW+1];
  logic [2:0][DvdW-1:0]     ddvd  [DvdW+1];
  mdm_pkg::div_lane_t [2:0] dlane [DvdW+1];

  mdm_pkg::side_t           sq_side [RW+1];
  logic [RW-1:0]            sq_mean [RW+1];
  mdm_pkg::sq_lane_t [1:0]  sq_lane [RW+1];

  logic          out_valid_q;
  logic [RW-1:0] mean_q, dev_q, dom_q;
  logic [1:0]    status_q;
  logic [RW-1:0] mean_d, dev_d, dom_d;

  // The chain only freezes while a finished beat waits downstream.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = out_valid_q & out_stall_i;

  mdm_prep #(.FRAC_BITS(FRAC_BITS), .DvdW(DvdW)) u_prep (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .in_valid_i    (in_valid_i),
    .sample_sum_i  (sample_sum_i),
    .square_sum_i  (square_sum_i),
    .sample_count_i(sample_count_i),
    .side_o        (dside[0]),
    .dvd_o         (ddvd[0]),
    .lane_o        (dlane[0])
  );

  genvar gi;
  for (gi = 0; gi < DvdW; gi++) begin : g_div
    mdm_div_cell #(.DvdW(DvdW)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i  (en),
      .side_i(dside[gi]),
      .side_o(dside[gi+1]),
      .dvd_i (ddvd[gi]),
      .dvd_o (ddvd[gi+1]),
      .lane_i(dlane[gi]),
      .lane_o(dlane[gi+1])
    );
  end

  // A quotient of 2^96 or more saturates the root; a mean of 2^48 or more saturates to 2^48 - 1.
  always_comb begin
    sq_side[0] = dside[DvdW];
    if (dlane[DvdW][0].ovf || dlane[DvdW][0].quo[WW-1:RW] != '0) begin
      sq_mean[0] = mdm_pkg::RootMax;
    end else begin
      sq_mean[0] = dlane[DvdW][0].quo[RW-1:0];
    end
    for (int k = 0; k < 2; k++) begin
      sq_lane[0][k].rad  = dlane[DvdW][k+1].quo;
      sq_lane[0][k].rem  = '0;
      sq_lane[0][k].root = '0;
      sq_lane[0][k].sat  = dlane[DvdW][k+1].ovf;
    end
  end

  for (gi = 0; gi < RW; gi++) begin : g_sq
    mdm_sq_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i  (en),
      .side_i(sq_side[gi]),
      .side_o(sq_side[gi+1]),
      .mean_i(sq_mean[gi]),
      .mean_o(sq_mean[gi+1]),
      .lane_i(sq_lane[gi]),
      .lane_o(sq_lane[gi+1])
    );
  end

  always_comb begin
    mean_d = sq_mean[RW];
    dev_d  = sq_lane[RW][0].sat ? mdm_pkg::RootMax : sq_lane[RW][0].root;
    dom_d  = sq_lane[RW][1].sat ? mdm_pkg::RootMax : sq_lane[RW][1].root;
    if (sq_side[RW].status != mdm_pkg::ST_OK) begin
      mean_d = '0;
      dev_d  = '0;
      dom_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_side[RW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mean_q   <= mean_d;
      dev_q    <= dev_d;
      dom_q    <= dom_d;
      status_q <= sq_side[RW].status;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mean_value_o        = mean_q;
  assign deviation_o         = dev_q;
  assign deviation_of_mean_o = dom_q;
  assign status_o            = status_q;

`include "mean_and_deviation_from_moments_top_assert.svh"

  `MDM_ASSERT_IMP(a_fail_zeroes, out_valid_o && (status_o != mdm_pkg::ST_OK), mean_value_o == '0 && deviation_o == '0 && deviation_of_mean_o == '0, "Failed status with nonzero values.")
  `MDM_ASSERT_IMP(a_dom_le_dev, out_valid_o && (status_o == mdm_pkg::ST_OK), deviation_of_mean_o <= deviation_o, "Deviation of mean above deviation.")
  `MDM_ASSERT_NXT(a_chain_frozen, out_valid_o && out_stall_i, $stable(sq_side[RW]), "Chain moved while output stalled.")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the mean and deviation pipeline.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned FracBits   = mdm_pkg::FracBitsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 220;
  localparam int unsigned LongHold   = 400;

  typedef struct packed {
    logic [31:0] sum;
    logic [63:0] sq;
    logic [31:0] cnt;
  } moments_t;

  typedef struct packed {
    logic [47:0]      mean;
    logic [47:0]      dev;
    logic [47:0]      dev_mean;
    mdm_pkg::status_e status;
  } stats_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_sum_i = '0;
  logic [63:0] square_sum_i = '0;
  logic [31:0] sample_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [47:0] mean_value_o;
  logic [47:0] deviation_o;
  logic [47:0] deviation_of_mean_o;
  logic [1:0]  status_o;

  stats_t      stats_pending[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  mean_and_deviation_from_moments_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_sum_i        (sample_sum_i),
    .square_sum_i        (square_sum_i),
    .sample_count_i      (sample_count_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .mean_value_o        (mean_value_o),
    .deviation_o         (deviation_o),
    .deviation_of_mean_o (deviation_of_mean_o),
    .status_o            (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Floor square root of a 128-bit radicand, saturated to 48 bits.
  function automatic logic [47:0] root_sat(logic [127:0] x);
    logic [47:0] r;
    logic [47:0] c;
    r = '0;
    if (x[127:96] != '0) return '1;
    for (int b = 47; b >= 0; b--) begin
      c = r | (48'd1 << b);
      if (96'(c) * 96'(c) <= x[95:0]) r = c;
    end
    return r;
  endfunction

  function automatic stats_t predict_stats(moments_t m);
    stats_t       r;
    logic [95:0]  nq;
    logic [95:0]  ss;
    logic [63:0]  mean_w;
    logic [63:0]  den;
    logic [127:0] var_s;
    r = '0;
    if (m.cnt == '0) begin
      r.status = mdm_pkg::ST_COUNT_ZERO;
    end else if (m.cnt == 32'd1) begin
      r.status = mdm_pkg::ST_COUNT_ONE;
    end else begin
      nq = 96'(m.cnt) * 96'(m.sq);
      ss = 96'(m.sum) * 96'(m.sum);
      if (nq < ss) begin
        r.status = mdm_pkg::ST_NEG_DIFF;
      end else begin
        r.status = mdm_pkg::ST_OK;
        mean_w   = (64'(m.sum) << FracBits) / 64'(m.cnt);
        r.mean   = (mean_w > 64'(mdm_pkg::RootMax)) ? mdm_pkg::RootMax : mean_w[47:0];
        den      = 64'(m.cnt) * 64'(m.cnt - 32'd1);
        var_s    = (128'(nq - ss) << (2 * FracBits)) / 128'(den);
        r.dev    = root_sat(var_s);
        r.dev_mean = root_sat(var_s / 128'(m.cnt));
      end
    end
    return r;
  endfunction

  // Offers one beat after a random gap (none while no_idle is set) and returns once it is accepted.
  task automatic send_moments(moments_t m);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_sum_i   <= m.sum;
    square_sum_i   <= m.sq;
    sample_count_i <= m.cnt;
    do begin
      @(negedge clk_i);
      if (!in_stall_o) stats_pending.push_back(predict_stats(m));
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // The sender goes idle first, so the last beat is not offered again.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (stats_pending.size() != 0) @(posedge clk_i);
  endtask

  // Output stall: random per result, plus a long hold on request.
  initial begin
    int unsigned n;
    bit          took;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // Outputs are stable at the falling edge, so the beat is judged there.
  always @(negedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_pending.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = stats_pending.pop_front();
        if (mean_value_o !== e.mean) begin
          $error("mean_value exp %h got %h", e.mean, mean_value_o);
          err_cnt++;
        end
        if (deviation_o !== e.dev) begin
          $error("deviation exp %h got %h", e.dev, deviation_o);
          err_cnt++;
        end
        if (deviation_of_mean_o !== e.dev_mean) begin
          $error("deviation_of_mean exp %h got %h", e.dev_mean, deviation_of_mean_o);
          err_cnt++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o);
          err_cnt++;
        end
      end
    end
  end

  function automatic moments_t noise_moments();
    moments_t m;
    m.sum = $urandom();
    m.sq  = {$urandom(), $urandom()};
    m.cnt = $urandom();
    return m;
  endfunction

  // Consistent sums: the square sum sits at or above sum^2 / count.
  function automatic moments_t sane_moments();
    moments_t     m;
    logic [127:0] q_min;
    logic [127:0] q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: m.cnt = $urandom_range(2, 64);
      5, 6:          m.cnt = $urandom_range(2, 100000);
      default:       m.cnt = $urandom() | 32'd2;
    endcase
    case ($urandom_range(0, 3))
      0:       m.sum = $urandom_range(0, 1000);
      1:       m.sum = m.cnt * $urandom_range(0, 50);
      default: m.sum = $urandom();
    endcase
    q_min = (128'(m.sum) * 128'(m.sum) + 128'(m.cnt) - 1) / 128'(m.cnt);
    case ($urandom_range(0, 4))
      0:       q = q_min;
      1:       q = q_min + $urandom_range(0, 100);
      2:       q = q_min + $urandom();
      default: q = q_min + {$urandom(), $urandom()};
    endcase
    m.sq = (q[127:64] != '0) ? '1 : q[63:0];
    return m;
  endfunction

  task automatic test_directed();
    moments_t dir[$];
    dir.push_back('{32'd0, 64'd0, 32'd0});
    dir.push_back('{32'hFFFF_FFFF, '1, 32'd0});
    dir.push_back('{32'd7, 64'd49, 32'd1});
    dir.push_back('{32'hFFFF_FFFF, '1, 32'd1});
    dir.push_back('{32'd10, 64'd0, 32'd2});
    dir.push_back('{32'hFFFF_FFFF, 64'd0, 32'hFFFF_FFFF});
    dir.push_back('{32'd0, 64'd0, 32'd2});
    dir.push_back('{32'd6, 64'd18, 32'd2});
    dir.push_back('{32'd3, 64'd5, 32'd2});
    dir.push_back('{32'hFFFF_FFFF, '1, 32'hFFFF_FFFF});
    dir.push_back('{32'hFFFF_FFFF, '1, 32'd2});
    dir.push_back('{32'd0, '1, 32'd2});
    dir.push_back('{32'd0, '1, 32'hFFFF_FFFF});
    dir.push_back('{32'hFFFF_FFFF, 64'd0, 32'd2});
    dir.push_back('{32'd1, 64'd1, 32'hFFFF_FFFF});
    dir.push_back('{32'd12, 64'd50, 32'd3});
    dir.push_back('{32'd12, 64'd47, 32'd3});
    dir.push_back('{32'd100, 64'd1000, 32'd10});
    dir.push_back('{32'h8000_0000, 64'h8000_0000_0000_0000, 32'h8000_0000});
    foreach (dir[i]) send_moments(dir[i]);
  endtask

  // Output held off while input keeps coming, so the chain fills and stalls.
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (300) send_moments(sane_moments());
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sums();
    for (int i = 0; i < 1100; i++) begin
      no_idle = (i >= 500 && i < 650);
      send_moments(sane_moments());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_noise();
    repeat (280) send_moments(noise_moments());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random_sums();
    test_random_noise();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0 && stats_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
